/* rtl/prbt_pkg.sv */
// Package for the priority bitmap ready table: sizes, request and status
// codes, and the search result bundle. No dependencies.
package prbt_pkg;

  localparam int NumPrios  = 64;
  localparam int NumCpus   = 4;
  localparam int CountBits = 8;

  localparam int NumTables = NumCpus + 1;
  localparam int TblW      = (NumTables > 1) ? $clog2(NumTables) : 1;
  localparam int PrioIdxW  = $clog2(NumPrios);
  localparam int AddrW     = $clog2(NumTables * NumPrios);
  localparam int Depth     = NumTables * NumPrios;

  // fixed field widths of the word
  localparam int ReqW  = 2;
  localparam int CpuW  = 2;
  localparam int PrioW = 6;
  localparam int StatW = 2;

  localparam logic [CountBits-1:0] CountMax = '1;

  typedef enum logic [ReqW-1:0] {
    ReqAdd    = 2'd0,
    ReqRemove = 2'd1,
    ReqGet    = 2'd2
  } req_type_e;

  typedef enum logic [StatW-1:0] {
    StDone      = 2'd0,
    StNone      = 2'd1,
    StSaturated = 2'd2,
    StEmpty     = 2'd3
  } status_e;

  typedef struct packed {
    logic             none;
    logic             from_global;
    logic [PrioW-1:0] best;
  } srch_res_t;

endpackage

/* rtl/prbt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module prbt_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/prbt_search.sv */
// Best-priority search over a local and the global ready bitmap.
// Depends on prbt_pkg.
module prbt_search
  import prbt_pkg::*;
(
  input  logic [NumPrios-1:0] lmap_i,
  input  logic [NumPrios-1:0] gmap_i,
  output srch_res_t           res_o
);

  logic             l_any;
  logic             g_any;
  logic [PrioW-1:0] lp;
  logic [PrioW-1:0] gp;

  // lowest set bit wins: scan from the top so the last hit is the lowest
  always_comb begin
    lp = '0;
    gp = '0;
    for (int i = NumPrios - 1; i >= 0; i--) begin
      if (lmap_i[i]) begin
        lp = PrioW'(i);
      end
      if (gmap_i[i]) begin
        gp = PrioW'(i);
      end
    end
  end

  assign l_any = |lmap_i;
  assign g_any = |gmap_i;

  always_comb begin
    res_o = '0;
    if (!l_any && !g_any) begin
      res_o.none = 1'b1;
    end else if (!l_any) begin
      res_o.from_global = 1'b1;
      res_o.best        = gp;
    end else if (!g_any || lp <= gp) begin
      // tie goes to the local table
      res_o.best = lp;
    end else begin
      res_o.from_global = 1'b1;
      res_o.best        = gp;
    end
  end

endmodule

/* rtl/priority_bitmap_ready_table_unit.sv */
// Top level of the priority bitmap ready table: input register, count RAM,
// count update and bitmap search. Depends on prbt_pkg, prbt_ram, prbt_search.
//
//  channel | valid      | stall      | word
//  --------+------------+------------+------------------------------------------
//  in      | in_valid_i | in_stall_o | req_type_i cpu_id_i pinned_i priority_req_i
//  out     | out_valid_o| out_stall_i| status_o from_global_o best_priority_o
//
// One word per cycle unless the output stalls; a word goes through stage 1 and
// then the output register. The count RAM read is launched as the word is
// taken; the update stage writes it back as the word leaves stage 1, with a
// one-entry bypass for back-to-back hits. Reset clears the bitmaps at once; a
// count whose bitmap bit is clear reads as zero, so the RAM needs no clearing
// pass. A stalled output holds the update stage, which then stalls the input.
module priority_bitmap_ready_table_unit
  import prbt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ReqW-1:0]  req_type_i,
  input  logic [CpuW-1:0]  cpu_id_i,
  input  logic             pinned_i,
  input  logic [PrioW-1:0] priority_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [StatW-1:0] status_o,
  output logic             from_global_o,
  output logic [PrioW-1:0] best_priority_o
);

  // input side
  logic                in_acc;
  logic                in_ok;
  logic [TblW-1:0]     in_tbl;
  logic [PrioIdxW-1:0] in_pidx;
  logic [AddrW-1:0]    in_addr;

  // stage 1
  logic                s1_valid_q;
  logic [ReqW-1:0]     s1_req_q;
  logic [CpuW-1:0]     s1_cpu_q;
  logic                s1_ok_q;
  logic [TblW-1:0]     s1_tbl_q;
  logic [PrioIdxW-1:0] s1_pidx_q;
  logic [AddrW-1:0]    s1_addr_q;
  logic                s1_fire;

  // bitmaps and bypass
  logic [NumPrios-1:0]  bits_q [NumTables];
  logic                 fwd_valid_q;
  logic [AddrW-1:0]     fwd_addr_q;
  logic [CountBits-1:0] fwd_data_q;

  // update stage
  logic [CountBits-1:0] ram_rdata;
  logic [CountBits-1:0] cnt_raw;
  logic [CountBits-1:0] cnt;
  logic [CountBits-1:0] cnt_new;
  logic                 cur_bit;
  logic                 wr_en;
  logic                 set_bit;
  logic                 clr_bit;
  logic [StatW-1:0]     status_d;
  logic                 glob_d;
  logic [PrioW-1:0]     best_d;
  logic [NumPrios-1:0]  lmap;
  logic [TblW-1:0]      loc_tbl;
  logic                 loc_ok;
  srch_res_t            srch;

  // output register
  logic             out_valid_q;
  logic [StatW-1:0] status_q;
  logic             glob_q;
  logic [PrioW-1:0] best_q;

  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_acc     = in_valid_i && !in_stall_o;

  // pick the table and check ranges; out-of-range words touch nothing
  always_comb begin
    in_ok   = (int'(priority_req_i) < NumPrios);
    in_tbl  = TblW'(NumCpus);
    if (pinned_i) begin
      if (int'(cpu_id_i) < NumCpus) begin
        in_tbl = TblW'(cpu_id_i);
      end else begin
        in_ok = 1'b0;
      end
    end
    if (!in_ok) begin
      in_tbl = '0;
    end
    in_pidx = in_ok ? priority_req_i[PrioIdxW-1:0] : '0;
    in_addr = AddrW'(int'(in_tbl) * NumPrios + int'(in_pidx));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q  <= req_type_i;
      s1_cpu_q  <= cpu_id_i;
      s1_ok_q   <= in_ok;
      s1_tbl_q  <= in_tbl;
      s1_pidx_q <= in_pidx;
      s1_addr_q <= in_addr;
    end
  end

  prbt_ram #(
    .Width (CountBits),
    .Depth (Depth)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (cnt_new),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  assign cur_bit = bits_q[s1_tbl_q][s1_pidx_q];
  assign cnt_raw = (fwd_valid_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : ram_rdata;
  // a clear bitmap bit means the count is zero, whatever the RAM holds
  assign cnt     = cur_bit ? cnt_raw : '0;

  assign loc_ok  = (int'(s1_cpu_q) < NumCpus);
  assign loc_tbl = loc_ok ? TblW'(s1_cpu_q) : '0;
  assign lmap    = loc_ok ? bits_q[loc_tbl] : '0;

  prbt_search u_search (
    .lmap_i (lmap),
    .gmap_i (bits_q[NumCpus]),
    .res_o  (srch)
  );

  always_comb begin
    wr_en    = 1'b0;
    set_bit  = 1'b0;
    clr_bit  = 1'b0;
    cnt_new  = cnt;
    status_d = StDone;
    glob_d   = 1'b0;
    best_d   = '0;
    case (req_type_e'(s1_req_q))
      ReqAdd: begin
        if (s1_ok_q) begin
          if (cnt == CountMax) begin
            status_d = StSaturated;
          end else begin
            cnt_new = cnt + CountBits'(1);
            wr_en   = s1_fire;
            set_bit = s1_fire && (cnt == '0);
          end
        end
      end
      ReqRemove: begin
        if (s1_ok_q) begin
          if (cnt == '0) begin
            status_d = StEmpty;
          end else begin
            cnt_new = cnt - CountBits'(1);
            wr_en   = s1_fire;
            clr_bit = s1_fire && (cnt == CountBits'(1));
          end
        end
      end
      ReqGet: begin
        if (srch.none) begin
          status_d = StNone;
        end else begin
          glob_d = srch.from_global;
          best_d = srch.best;
        end
      end
      default: begin
        status_d = StDone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NumTables; t++) begin
        bits_q[t] <= '0;
      end
      fwd_valid_q <= 1'b0;
    end else begin
      if (set_bit) begin
        bits_q[s1_tbl_q][s1_pidx_q] <= 1'b1;
      end else if (clr_bit) begin
        bits_q[s1_tbl_q][s1_pidx_q] <= 1'b0;
      end
      if (wr_en) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  // hold the last write: the next word's RAM read raced it
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_q <= status_d;
      glob_q   <= glob_d;
      best_q   <= best_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign from_global_o   = glob_q;
  assign best_priority_o = best_q;

endmodule

/* rtl/prbt_checker.sv */
// Port-level checks for the priority bitmap ready table, bound to the top.
// Depends on prbt_pkg and priority_bitmap_ready_table_unit.
module prbt_checker
  import prbt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [StatW-1:0] status_o,
  input logic             from_global_o,
  input logic [PrioW-1:0] best_priority_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(from_global_o)
      && $stable(best_priority_o))
    else $error("stalled output word changed");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StDone |-> !from_global_o && best_priority_o == '0)
    else $error("non-done status carries a priority");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

endmodule

bind priority_bitmap_ready_table_unit prbt_checker u_prbt_checker (.*);
